[rtl/core/see_pkg.sv]
// see_pkg: shared types, character constants and encode functions for the
// string escape encoder. No dependencies; imported by every see_* module.
package see_pkg;

  // ASCII characters used by the escaped form
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOWA   = 8'h61;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Step position within one escape run
  localparam logic [1:0] STEP_FIRST = 2'd0;
  localparam logic [1:0] STEP_SECOND = 2'd1;
  localparam logic [1:0] STEP_THIRD = 2'd2;

  // Classification of one raw byte
  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,  // printable, passed through
    KIND_CTRL  = 2'd1,  // \a .. \r letter escape
    KIND_PAIR  = 2'd2,  // backslash or double quote, escaped with backslash
    KIND_HEX   = 2'd3   // \xHH
  } kind_t;

  // One classified byte as held in the queue
  typedef struct packed {
    kind_t      kind;
    logic [7:0] raw;
  } entry_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic nempty;
  } q_status_t;

  // One output character with its end-of-run mark
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_t;

  function automatic kind_t classify(input logic [7:0] b);
    kind_t k;
    if (b >= CH_BEL && b <= CH_CR)
      k = KIND_CTRL;
    else if (b == CH_BSLASH || b == CH_DQUOTE)
      k = KIND_PAIR;
    else if (b >= CH_SPACE && b <= CH_TILDE)
      k = KIND_PLAIN;
    else
      k = KIND_HEX;
    return k;
  endfunction

  // Letter for the control escapes 0x07..0x0D
  function automatic logic [7:0] ctrl_letter(input logic [7:0] b);
    logic [7:0] c;
    unique case (b[3:0])
      4'h7:    c = 8'h61;  // a
      4'h8:    c = 8'h62;  // b
      4'h9:    c = 8'h74;  // t
      4'hA:    c = 8'h6E;  // n
      4'hB:    c = 8'h76;  // v
      4'hC:    c = 8'h66;  // f
      4'hD:    c = 8'h72;  // r
      default: c = CH_BSLASH;
    endcase
    return c;
  endfunction

  // Lower-case hex digit for one nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10)
      c = CH_ZERO + {4'd0, n};
    else
      c = CH_LOWA + {4'd0, n - 4'd10};
    return c;
  endfunction

  // Character at a given step of the run for one entry
  function automatic char_t encode(input entry_t e, input logic [1:0] step);
    char_t r;
    r.ch   = CH_BSLASH;
    r.last = 1'b0;
    unique case (e.kind)
      KIND_PLAIN: begin
        r.ch   = e.raw;
        r.last = 1'b1;
      end
      KIND_CTRL: begin
        if (step != STEP_FIRST) begin
          r.ch   = ctrl_letter(e.raw);
          r.last = 1'b1;
        end
      end
      KIND_PAIR: begin
        if (step != STEP_FIRST) begin
          r.ch   = e.raw;
          r.last = 1'b1;
        end
      end
      KIND_HEX: begin
        case (step)
          STEP_FIRST:  r.ch = CH_BSLASH;
          STEP_SECOND: r.ch = CH_X;
          STEP_THIRD:  r.ch = hex_digit(e.raw[7:4]);
          default: begin
            r.ch   = hex_digit(e.raw[3:0]);
            r.last = 1'b1;
          end
        endcase
      end
      default: r.ch = CH_BSLASH;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/see_front.sv]
// see_front: input stage; registers each raw byte together with its class
// and hands it to the queue. Depends on see_pkg.
module see_front import see_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  q_status_t  q_stat,
  output logic       q_wr,
  output entry_t     q_wdata
);

  logic   valid_r, valid_nxt;
  entry_t entry_r, entry_nxt;
  logic   take;

  // Hold register drains into the queue whenever the queue has room
  assign q_wr    = valid_r & ~q_stat.full;
  assign q_wdata = entry_r;
  assign full    = valid_r & q_stat.full;
  assign take    = push & ~full;

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (take) begin
      valid_nxt      = 1'b1;
      entry_nxt.kind = classify(in_byte);
      entry_nxt.raw  = in_byte;
    end else if (q_wr) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

[rtl/core/see_queue.sv]
// see_queue: short register queue of classified bytes between the front
// and the back. Depends on see_pkg.
module see_queue import see_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr,
  input  entry_t    wdata,
  input  logic      rd,
  output entry_t    rdata,
  output q_status_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t          mem_r [DEPTH];
  logic [PW-1:0]   wptr_r, wptr_nxt;
  logic [PW-1:0]   rptr_r, rptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_wr, do_rd;

  assign stat.full   = (cnt_r == FULL_CNT);
  assign stat.nempty = (cnt_r != '0);
  assign do_wr       = wr & ~stat.full;
  assign do_rd       = rd & stat.nempty;
  assign rdata       = mem_r[rptr_r];

  // Pointer and count update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr)
      wptr_nxt = (wptr_r == LAST_PTR) ? '0 : wptr_r + 1'b1;
    if (do_rd)
      rptr_nxt = (rptr_r == LAST_PTR) ? '0 : rptr_r + 1'b1;
    if (do_wr && !do_rd)
      cnt_nxt = cnt_r + 1'b1;
    else if (do_rd && !do_wr)
      cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_wr)
      mem_r[wptr_r] <= wdata;
  end

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("queue count above depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == FULL_CNT) |-> (wptr_r == rptr_r))
    else $error("queue pointers disagree with count");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not follow a write");

endmodule

[rtl/core/see_back.sv]
// see_back: takes classified bytes from the queue and steps through their
// escaped characters into the output register. Depends on see_pkg.
module see_back import see_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  q_status_t  q_stat,
  input  entry_t     q_rdata,
  output logic       q_rd,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       out_run_last
);

  logic       act_r, act_nxt;
  entry_t     entry_r, entry_nxt;
  logic [1:0] step_r, step_nxt;
  logic       ov_r, ov_nxt;
  char_t      oreg_r, oreg_nxt;
  char_t      cur;
  logic       out_pop, out_free, adv, take;

  // Output register handshake
  assign out_pop      = pop & ov_r;
  assign out_free     = ~ov_r | out_pop;
  assign empty        = ~ov_r;
  assign out_char     = oreg_r.ch;
  assign out_run_last = oreg_r.last;

  // Character for the current step, one per cycle into the output register while it is free
  assign cur  = encode(entry_r, step_r);
  assign adv  = act_r & out_free;
  assign take = (~act_r | (adv & cur.last)) & q_stat.nempty;
  assign q_rd = take;

  always_comb begin
    act_nxt   = act_r;
    entry_nxt = entry_r;
    step_nxt  = step_r;
    ov_nxt    = ov_r;
    oreg_nxt  = oreg_r;
    if (take) begin
      act_nxt   = 1'b1;
      entry_nxt = q_rdata;
      step_nxt  = STEP_FIRST;
    end else if (adv) begin
      if (cur.last)
        act_nxt = 1'b0;
      else
        step_nxt = step_r + 1'b1;
    end
    if (adv) begin
      ov_nxt   = 1'b1;
      oreg_nxt = cur;
    end else if (out_pop) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      act_r <= act_nxt;
      ov_r  <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    step_r  <= step_nxt;
    oreg_r  <= oreg_nxt;
  end

  // Checks
  a_short_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r && entry_r.kind != KIND_HEX) |-> (step_r == STEP_FIRST || step_r == STEP_SECOND))
    else $error("step past end of a short run");

  a_plain_one: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r && entry_r.kind == KIND_PLAIN) |-> (step_r == STEP_FIRST))
    else $error("plain byte given more than one character");

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !pop) |=> (ov_r && oreg_r == $past(oreg_r)))
    else $error("waiting output character changed");

endmodule

[rtl/core/string_escape_encoder.sv]
// string_escape_encoder: top level; front stage, classified-byte queue and
// back sequencer. Depends on see_pkg, see_front, see_queue, see_back.
//
//   channel | ports                          | handshake
//   --------+--------------------------------+------------------------------
//   input   | in_byte[7:0]                   | push / full, taken on push & !full
//   result  | out_char[7:0], out_run_last    | empty / pop, taken on pop & !empty
//
// One output character leaves per cycle while pop drains the result
// port; a byte gives 1, 2 or 4 characters (plain, letter/pair escape,
// hex escape) via the back's step counter and single output register.
// A byte's first character passes front hold, queue, back entry and output registers.
// Reset clears the valid flags and queue pointers; no clearing pass.
// A stalled result port fills the queue, then full rises; input keeps
// flowing while results wait, up to QUEUE_DEPTH + 3 bytes in flight.
module string_escape_encoder import see_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       out_run_last
);

  q_status_t q_stat;
  logic      q_wr, q_rd;
  entry_t    q_wdata, q_rdata;

  // Accept and classify
  see_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_byte (in_byte),
    .q_stat  (q_stat),
    .q_wr    (q_wr),
    .q_wdata (q_wdata)
  );

  // Decoupling queue
  see_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Emit escaped characters
  see_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .q_rdata      (q_rdata),
    .q_rd         (q_rd),
    .empty        (empty),
    .pop          (pop),
    .out_char     (out_char),
    .out_run_last (out_run_last)
  );

endmodule

[sim/testbench.sv]
// testbench: self-checking regression for string_escape_encoder; expands each
// accepted byte into its escaped characters and checks every result transaction.
// Depends on see_pkg and the string_escape_encoder RTL.
module testbench;
  import see_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_BYTES = 250;
  localparam int HOLD_AT      = 40;
  localparam int HOLD_CYCLES  = 100;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_LIMIT = 10;
  localparam int TIMEOUT      = 2000000;

  // Expected characters in order, checked against each result transaction
  class escape_scoreboard;
    char_t       expected_chars[$];
    int unsigned mismatches;

    // Expand one raw byte into its escaped run
    function void note_byte(logic [7:0] b);
      kind_t      kind;
      logic [7:0] letter;
      if (b >= 8'h07 && b <= 8'h0D)
        kind = KIND_CTRL;
      else if (b == CH_BSLASH || b == CH_DQUOTE)
        kind = KIND_PAIR;
      else if (b >= 8'h20 && b <= 8'h7E)
        kind = KIND_PLAIN;
      else
        kind = KIND_HEX;
      case (kind)
        KIND_PLAIN: begin
          expected_chars.push_back('{ch: b, last: 1'b1});
        end
        KIND_CTRL: begin
          case (b)
            8'h07:   letter = "a";
            8'h08:   letter = "b";
            8'h09:   letter = "t";
            8'h0A:   letter = "n";
            8'h0B:   letter = "v";
            8'h0C:   letter = "f";
            default: letter = "r";
          endcase
          expected_chars.push_back('{ch: CH_BSLASH, last: 1'b0});
          expected_chars.push_back('{ch: letter, last: 1'b1});
        end
        KIND_PAIR: begin
          expected_chars.push_back('{ch: CH_BSLASH, last: 1'b0});
          expected_chars.push_back('{ch: b, last: 1'b1});
        end
        default: begin
          expected_chars.push_back('{ch: CH_BSLASH, last: 1'b0});
          expected_chars.push_back('{ch: "x", last: 1'b0});
          expected_chars.push_back('{ch: nibble_char(b[7:4]), last: 1'b0});
          expected_chars.push_back('{ch: nibble_char(b[3:0]), last: 1'b1});
        end
      endcase
    endfunction

    function logic [7:0] nibble_char(logic [3:0] n);
      if (n < 4'd10)
        return 8'h30 + {4'd0, n};
      return 8'h61 + {4'd0, n} - 8'd10;
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("mismatch at %0t: %s", $time, what);
    endfunction

    // Compare one accepted character with the oldest expectation
    function void check_char(logic [7:0] ch, logic last);
      char_t want;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected char %02h last %0b", ch, last));
      end else begin
        want = expected_chars.pop_front();
        if (ch !== want.ch)
          report($sformatf("out_char expected %02h actual %02h", want.ch, ch));
        if (last !== want.last)
          report($sformatf("out_run_last expected %0b actual %0b", want.last, last));
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_char;
  logic       out_run_last;

  escape_scoreboard sb = new();
  int unsigned      bytes_accepted = 0;

  string_escape_encoder u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_byte     (in_byte),
    .empty       (empty),
    .pop         (pop),
    .out_char    (out_char),
    .out_run_last(out_run_last)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Watch both channels; values sampled are those before the edge
  always @(posedge clk) begin
    if (rst_n && push && !full) begin
      sb.note_byte(in_byte);
      bytes_accepted++;
    end
    if (rst_n && pop && !empty)
      sb.check_char(out_char, out_run_last);
  end

  // Offer one byte and hold it until the input transaction completes
  task automatic send_byte(input logic [7:0] b);
    push    <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Drop push for a gap, with noise on the data lines
  task automatic idle_sender(input int cycles);
    push <= 1'b0;
    repeat (cycles) begin
      in_byte <= 8'($urandom);
      @(posedge clk);
    end
  endtask

  // Random byte leaning on each class of the mapping
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      4:       return 8'($urandom_range(8'h07, 8'h0D));
      5:       return ($urandom_range(0, 1) != 0) ? CH_BSLASH : CH_DQUOTE;
      6:       return 8'($urandom_range(8'h20, 8'h7E));
      7:       return 8'($urandom_range(8'h00, 8'h1F));
      8:       return 8'($urandom_range(8'h7F, 8'hFF));
      default: return 8'($urandom);
    endcase
  endfunction

  // Receiver: segments of free flow, random stalls and a fixed pattern,
  // plus one long hold-off so the queue fills and full rises
  initial begin
    int  seg_len;
    int  mode;
    bit  held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && bytes_accepted >= HOLD_AT) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode    = $urandom_range(0, 2);
      seg_len = $urandom_range(4, 40);
      for (int i = 0; i < seg_len; i++) begin
        case (mode)
          0:       pop <= 1'b1;
          1:       pop <= ($urandom_range(0, 2) != 0);
          default: pop <= (i % 5 < 2);
        endcase
        @(posedge clk);
      end
    end
  end

  // Main sequence: reset, directed bytes, random bursts, drain
  initial begin
    logic [7:0] directed[$];
    int         burst;
    int         sent;
    directed = '{8'h00, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D,
                 8'h0E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h5C, 8'h7E, 8'h7F, 8'h80,
                 8'hA5, 8'hFF, 8'h01, 8'h33, 8'h61, 8'h41};
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: class boundaries, every letter escape, hex escape then hex digit
    foreach (directed[i])
      send_byte(directed[i]);
    idle_sender(3);

    // Random bursts with random gaps, some back to back
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < RANDOM_BYTES; i++) begin
        send_byte(pick_byte());
        sent++;
      end
      if ($urandom_range(0, 3) != 0)
        idle_sender($urandom_range(1, 8));
    end
    push <= 1'b0;

    // Wait for every expected character, then for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("string_escape_encoder regression: pass");
    end else begin
      $display("string_escape_encoder regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT);
    $display("string_escape_encoder regression: fail");
    $finish;
  end

endmodule

[string_escape_encoder.f]
rtl/core/see_pkg.sv
rtl/core/see_front.sv
rtl/core/see_queue.sv
rtl/core/see_back.sv
rtl/core/string_escape_encoder.sv
sim/testbench.sv
